/* rtl/core/prpi_pkg.sv */
// ----------------------------------------------------------------------------
// prpi_pkg
// Shared constants, codes and types of the PageRank power-iteration core.
// ----------------------------------------------------------------------------
package prpi_pkg;

  // graph and store sizes
  localparam int MaxNodes = 64;
  localparam int NodeW    = 6;
  localparam int NodeCntW = 7;
  localparam int MaxEdges = 1024;
  localparam int EdgeAw   = 10;
  localparam int EdgeCntW = 11;
  localparam int DegW     = 11;

  // fixed-point widths, ranks are Q1.31
  localparam int RankW  = 32;
  localparam int AccW   = 33;
  localparam int DsumW  = 38;
  localparam int DivW   = 38;
  localparam int DivCntW = 6;
  localparam int ItW    = 16;
  localparam int DampW  = 16;
  localparam int ThrW   = 32;
  localparam logic [RankW-1:0] RankOne = 32'h8000_0000;

  // request codes
  localparam logic [1:0] ReqAdd    = 2'd0;
  localparam logic [1:0] ReqAddRun = 2'd1;
  localparam logic [1:0] ReqRun    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgNodeCount = 2'd0;
  localparam logic [1:0] CfgDamping   = 2'd1;
  localparam logic [1:0] CfgThreshold = 2'd2;
  localparam logic [1:0] CfgMaxIter   = 2'd3;

  typedef struct packed {
    logic [NodeCntW-1:0] node_count;
    logic [DampW-1:0]    damping;
    logic [ThrW-1:0]     threshold;
    logic [ItW-1:0]      max_iterations;
  } prpi_cfg_t;

  typedef struct packed {
    logic [NodeW-1:0] node_index;
    logic [RankW-1:0] rank_value;
    logic [ItW-1:0]   iterations_done;
    logic             converged;
    logic             last_result;
  } prpi_res_t;

endpackage

/* rtl/core/pagerank_power_iteration_core.sv */
// ----------------------------------------------------------------------------
// pagerank_power_iteration_core
// PageRank engine: edge loading, power iteration and per-node rank results.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one request per item. Add-edge
// requests are taken one per cycle while the core is idle. A run request
// (add-then-run or run) holds in_stall_o high until every result is handed
// to the output register.
// Output channel (out_valid_o / out_stall_i): one result per node 0..N-1,
// last_result_o marks node N-1. A registered output stage lets the core
// fetch the next node while the current one waits; a stalled result holds.
// Run steps: degree clear, one degree count per edge, start rank and
// teleport by division, then per pass a share per node with out-edges (the
// shared divider dominates), the dangling term, base init, one scatter per
// edge and the saturate-and-compare pass; readout then goes node by node.
// Reset empties the edge store and loads the default register values; the
// edge store and rank memories need no clearing pass.
// Configuration writes are taken any time the core is idle.
// ----------------------------------------------------------------------------
module pagerank_power_iteration_core import prpi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [ThrW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic [NodeW-1:0]    src_node_i,
  input  logic [NodeW-1:0]    dst_node_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [NodeW-1:0]    node_index_o,
  output logic [RankW-1:0]    rank_value_o,
  output logic [ItW-1:0]      iterations_done_o,
  output logic                converged_o,
  output logic                edges_dropped_o,
  output logic                last_result_o
);

  prpi_cfg_t           cfg_q;
  logic                busy, accept, add_edge, start_run;
  logic [EdgeCntW-1:0] total, e_addr;
  logic [NodeW-1:0]    e_src, e_dst;
  logic                e_rd, clear, ovf;
  logic                res_valid, res_ready;
  prpi_res_t           res;
  prpi_res_t           out_q;
  logic                out_valid_q, drop_q;

  // request decode
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign add_edge   = accept && (req_type_i == ReqAdd || req_type_i == ReqAddRun);
  assign start_run  = accept && (req_type_i == ReqAddRun || req_type_i == ReqRun);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_count     <= NodeCntW'(64);
      cfg_q.damping        <= DampW'(55706);
      cfg_q.threshold      <= ThrW'(2);
      cfg_q.max_iterations <= ItW'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNodeCount: cfg_q.node_count     <= cfg_data_i[NodeCntW-1:0];
        CfgDamping:   cfg_q.damping        <= cfg_data_i[DampW-1:0];
        CfgThreshold: cfg_q.threshold      <= cfg_data_i;
        CfgMaxIter:   cfg_q.max_iterations <= cfg_data_i[ItW-1:0];
        default: ;
      endcase
    end
  end

  prpi_edge_store u_edges (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (add_edge),
    .wr_src_i   (src_node_i),
    .wr_dst_i   (dst_node_i),
    .rd_en_i    (e_rd),
    .rd_addr_i  (e_addr),
    .clear_i    (clear),
    .total_o    (total),
    .overflow_o (ovf),
    .rd_src_o   (e_src),
    .rd_dst_o   (e_dst)
  );

  prpi_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_run),
    .cfg_i       (cfg_q),
    .total_i     (total),
    .e_src_i     (e_src),
    .e_dst_i     (e_dst),
    .e_rd_o      (e_rd),
    .e_addr_o    (e_addr),
    .clear_o     (clear),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (res_ready) out_valid_q <= res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q  <= res;
      drop_q <= ovf;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign node_index_o      = out_q.node_index;
  assign rank_value_o      = out_q.rank_value;
  assign iterations_done_o = out_q.iterations_done;
  assign converged_o       = out_q.converged;
  assign edges_dropped_o   = drop_q;
  assign last_result_o     = out_q.last_result;

endmodule

/* rtl/core/prpi_div.sv */
// ----------------------------------------------------------------------------
// prpi_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prpi_div import prpi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DegW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  logic [DivW-1:0]    quo_q, quo_d;
  logic [DegW-1:0]    rem_q, rem_d;
  logic [DegW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DegW:0]      part;
  logic               ge;

  // one shift and trial subtract per cycle
  always_comb begin
    part   = {rem_q, quo_q[DivW-1]};
    ge     = (part >= {1'b0, dvs_q});
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DegW'(part - {1'b0, dvs_q}) : part[DegW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/core/prpi_edge_store.sv */
// ----------------------------------------------------------------------------
// prpi_edge_store
// Edge memory with fill count and overflow flag.
// ----------------------------------------------------------------------------
module prpi_edge_store import prpi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [NodeW-1:0]    wr_src_i,
  input  logic [NodeW-1:0]    wr_dst_i,
  input  logic                rd_en_i,
  input  logic [EdgeCntW-1:0] rd_addr_i,
  input  logic                clear_i,
  output logic [EdgeCntW-1:0] total_o,
  output logic                overflow_o,
  output logic [NodeW-1:0]    rd_src_o,
  output logic [NodeW-1:0]    rd_dst_o
);

  logic [2*NodeW-1:0]  edge_mem [MaxEdges];
  logic [2*NodeW-1:0]  rd_q;
  logic [EdgeCntW-1:0] total_q, total_d;
  logic                ovf_q, ovf_d;
  logic                full;

  assign full = (total_q == EdgeCntW'(MaxEdges));

  // fill count and overflow
  always_comb begin
    total_d = total_q;
    ovf_d   = ovf_q;
    if (clear_i) begin
      total_d = '0;
      ovf_d   = 1'b0;
    end else if (wr_en_i) begin
      if (full) ovf_d = 1'b1;
      else      total_d = total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      total_q <= total_d;
      ovf_q   <= ovf_d;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !full) edge_mem[total_q[EdgeAw-1:0]] <= {wr_src_i, wr_dst_i};
    if (rd_en_i) rd_q <= edge_mem[rd_addr_i[EdgeAw-1:0]];
  end

  assign total_o    = total_q;
  assign overflow_o = ovf_q;
  assign rd_src_o   = rd_q[2*NodeW-1:NodeW];
  assign rd_dst_o   = rd_q[NodeW-1:0];

endmodule

/* rtl/core/prpi_engine.sv */
// ----------------------------------------------------------------------------
// prpi_engine
// Run sequencer: degree count, power-iteration passes and result readout
// over the rank, share and degree memories.
// ----------------------------------------------------------------------------
module prpi_engine import prpi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  prpi_cfg_t           cfg_i,
  input  logic [EdgeCntW-1:0] total_i,
  input  logic [NodeW-1:0]    e_src_i,
  input  logic [NodeW-1:0]    e_dst_i,
  output logic                e_rd_o,
  output logic [EdgeCntW-1:0] e_addr_o,
  output logic                clear_o,
  output logic                busy_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output prpi_res_t           res_o
);

  localparam logic [4:0] StIdle   = 5'd0;
  localparam logic [4:0] StDgClr  = 5'd1;
  localparam logic [4:0] StDgRd   = 5'd2;
  localparam logic [4:0] StDgChk  = 5'd3;
  localparam logic [4:0] StDgInc  = 5'd4;
  localparam logic [4:0] StStDiv  = 5'd5;
  localparam logic [4:0] StTlDiv  = 5'd6;
  localparam logic [4:0] StCurIni = 5'd7;
  localparam logic [4:0] StPass   = 5'd8;
  localparam logic [4:0] StShRd   = 5'd9;
  localparam logic [4:0] StShMul  = 5'd10;
  localparam logic [4:0] StShDiv  = 5'd11;
  localparam logic [4:0] StShWait = 5'd12;
  localparam logic [4:0] StDsMul  = 5'd13;
  localparam logic [4:0] StDsDiv  = 5'd14;
  localparam logic [4:0] StDsWait = 5'd15;
  localparam logic [4:0] StNxIni  = 5'd16;
  localparam logic [4:0] StEdRd   = 5'd17;
  localparam logic [4:0] StEdChk  = 5'd18;
  localparam logic [4:0] StEdUpd  = 5'd19;
  localparam logic [4:0] StCmpRd  = 5'd20;
  localparam logic [4:0] StCmp    = 5'd21;
  localparam logic [4:0] StPEnd   = 5'd22;
  localparam logic [4:0] StOutRd  = 5'd23;
  localparam logic [4:0] StOut    = 5'd24;

  // memories: two rank banks, per-node shares, per-node degrees
  logic [AccW-1:0]  rank_mem  [2*MaxNodes];
  logic [RankW-1:0] share_mem [MaxNodes];
  logic [DegW-1:0]  deg_mem   [MaxNodes];

  logic [4:0]          st_q, st_d;
  logic [NodeW-1:0]    idx_q, idx_d;
  logic [EdgeCntW-1:0] e_q, e_d;
  logic [NodeCntW-1:0] n_q, n_d;
  logic                cur_q, cur_d;
  logic                obank_q, obank_d;
  logic [ItW-1:0]      it_q, it_d;
  logic                moved_q, moved_d;
  logic                conv_q, conv_d;
  logic [DsumW-1:0]    dsum_q, dsum_d;
  logic [RankW-1:0]    tel_q, tel_d;
  logic [RankW-1:0]    init_q, init_d;
  logic [AccW-1:0]     base_q, base_d;
  logic [RankW-1:0]    scaled_q, scaled_d;
  logic [RankW-1:0]    rank_q, rank_d;
  logic [DegW-1:0]     deg_q, deg_d;
  logic [DsumW-1:0]    prod_q, prod_d;

  logic [AccW-1:0]     rk_a_q, rk_b_q, rk_wd;
  logic [NodeW:0]      rk_ra, rk_rb, rk_wa;
  logic                rk_we;
  logic [RankW-1:0]    sh_q, sh_wd;
  logic [NodeW-1:0]    sh_ra, sh_wa;
  logic                sh_we;
  logic [DegW-1:0]     dg_q, dg_wd;
  logic [NodeW-1:0]    dg_ra, dg_wa;
  logic                dg_we;

  logic                div_start, div_done;
  logic [DivW-1:0]     div_dvd, div_quot;
  logic [DegW-1:0]     div_dvs;

  logic                last_node;
  logic                edge_ok;
  logic [ItW-1:0]      guard;
  logic [47:0]         mul_r;
  logic [53:0]         mul_d;
  logic [RankW-1:0]    sat;
  logic [RankW-1:0]    diff;

  assign last_node = (idx_q == NodeW'(n_q - 1'b1));
  assign edge_ok   = ({1'b0, e_src_i} < n_q) && ({1'b0, e_dst_i} < n_q);
  assign guard     = (cfg_i.max_iterations == '0) ? ItW'(1) : cfg_i.max_iterations;
  assign mul_r     = cfg_i.damping * rk_a_q[RankW-1:0];
  assign mul_d     = cfg_i.damping * dsum_q;
  assign sat       = (rk_b_q > AccW'(RankOne)) ? RankOne : rk_b_q[RankW-1:0];
  assign diff      = (sat > rk_a_q[RankW-1:0]) ? (sat - rk_a_q[RankW-1:0])
                                              : (rk_a_q[RankW-1:0] - sat);

  prpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer
  always_comb begin
    st_d = st_q;  idx_d = idx_q;  e_d = e_q;  n_d = n_q;
    cur_d = cur_q;  obank_d = obank_q;  it_d = it_q;  moved_d = moved_q;
    conv_d = conv_q;  dsum_d = dsum_q;  tel_d = tel_q;  init_d = init_q;
    base_d = base_q;  scaled_d = scaled_q;  rank_d = rank_q;  deg_d = deg_q;
    prod_d = prod_q;
    rk_ra = {cur_q, idx_q};  rk_rb = {~cur_q, idx_q};
    rk_we = 1'b0;  rk_wa = {~cur_q, idx_q};  rk_wd = base_q;
    sh_ra = e_src_i;  sh_we = 1'b0;  sh_wa = idx_q;  sh_wd = '0;
    dg_ra = idx_q;  dg_we = 1'b0;  dg_wa = idx_q;  dg_wd = '0;
    div_start = 1'b0;  div_dvd = '0;  div_dvs = DegW'(n_q);
    e_rd_o = 1'b0;  clear_o = 1'b0;  res_valid_o = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          if (cfg_i.node_count == '0) n_d = NodeCntW'(1);
          else if (cfg_i.node_count > NodeCntW'(MaxNodes)) n_d = NodeCntW'(MaxNodes);
          else n_d = cfg_i.node_count;
          idx_d = '0;
          st_d  = StDgClr;
        end
      end
      // clear run-time degrees
      StDgClr: begin
        dg_we = 1'b1;
        if (last_node) begin
          e_d  = '0;
          st_d = StDgRd;
        end else idx_d = idx_q + 1'b1;
      end
      StDgRd: begin
        if (e_q == total_i) begin
          div_start = 1'b1;
          div_dvd   = DivW'(RankOne);
          st_d      = StStDiv;
        end else begin
          e_rd_o = 1'b1;
          st_d   = StDgChk;
        end
      end
      StDgChk: begin
        dg_ra = e_src_i;
        if (edge_ok) st_d = StDgInc;
        else begin
          e_d  = e_q + 1'b1;
          st_d = StDgRd;
        end
      end
      StDgInc: begin
        dg_we = 1'b1;
        dg_wa = e_src_i;
        dg_wd = dg_q + 1'b1;
        e_d   = e_q + 1'b1;
        st_d  = StDgRd;
      end
      // start rank and teleport term
      StStDiv: begin
        if (div_done) begin
          init_d    = div_quot[RankW-1:0];
          div_start = 1'b1;
          div_dvd   = DivW'({17'h10000 - {1'b0, cfg_i.damping}, 15'd0});
          st_d      = StTlDiv;
        end
      end
      StTlDiv: begin
        if (div_done) begin
          tel_d = div_quot[RankW-1:0];
          idx_d = '0;
          st_d  = StCurIni;
        end
      end
      StCurIni: begin
        rk_we = 1'b1;
        rk_wa = {cur_q, idx_q};
        rk_wd = AccW'(init_q);
        if (last_node) begin
          it_d = '0;
          st_d = StPass;
        end else idx_d = idx_q + 1'b1;
      end
      StPass: begin
        it_d   = it_q + 1'b1;
        idx_d  = '0;
        dsum_d = '0;
        st_d   = StShRd;
      end
      // per-node share of outgoing rank
      StShRd: st_d = StShMul;
      StShMul: begin
        rank_d   = rk_a_q[RankW-1:0];
        scaled_d = mul_r[47:16];
        deg_d    = dg_q;
        st_d     = StShDiv;
      end
      StShDiv: begin
        if (deg_q == '0) begin
          dsum_d = dsum_q + DsumW'(rank_q);
          sh_we  = 1'b1;
          if (last_node) st_d = StDsMul;
          else begin
            idx_d = idx_q + 1'b1;
            st_d  = StShRd;
          end
        end else begin
          div_start = 1'b1;
          div_dvd   = DivW'(scaled_q);
          div_dvs   = deg_q;
          st_d      = StShWait;
        end
      end
      StShWait: begin
        if (div_done) begin
          sh_we = 1'b1;
          sh_wd = div_quot[RankW-1:0];
          if (last_node) st_d = StDsMul;
          else begin
            idx_d = idx_q + 1'b1;
            st_d  = StShRd;
          end
        end
      end
      // dangling term and base rank
      StDsMul: begin
        prod_d = mul_d[53:16];
        st_d   = StDsDiv;
      end
      StDsDiv: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        st_d      = StDsWait;
      end
      StDsWait: begin
        if (div_done) begin
          base_d = AccW'(tel_q) + AccW'(div_quot);
          idx_d  = '0;
          st_d   = StNxIni;
        end
      end
      StNxIni: begin
        rk_we = 1'b1;
        if (last_node) begin
          e_d  = '0;
          st_d = StEdRd;
        end else idx_d = idx_q + 1'b1;
      end
      // edge scatter, one edge at a time so no read-after-write overlap
      StEdRd: begin
        if (e_q == total_i) begin
          idx_d   = '0;
          moved_d = 1'b0;
          st_d    = StCmpRd;
        end else begin
          e_rd_o = 1'b1;
          st_d   = StEdChk;
        end
      end
      StEdChk: begin
        rk_ra = {~cur_q, e_dst_i};
        if (edge_ok) st_d = StEdUpd;
        else begin
          e_d  = e_q + 1'b1;
          st_d = StEdRd;
        end
      end
      StEdUpd: begin
        rk_we = 1'b1;
        rk_wa = {~cur_q, e_dst_i};
        rk_wd = rk_a_q + AccW'(sh_q);
        e_d   = e_q + 1'b1;
        st_d  = StEdRd;
      end
      // saturate and compare against current ranks
      StCmpRd: st_d = StCmp;
      StCmp: begin
        rk_we = 1'b1;
        rk_wd = AccW'(sat);
        if (diff > cfg_i.threshold) moved_d = 1'b1;
        if (last_node) st_d = StPEnd;
        else begin
          idx_d = idx_q + 1'b1;
          st_d  = StCmpRd;
        end
      end
      StPEnd: begin
        idx_d   = '0;
        obank_d = ~cur_q;
        if (!moved_q) begin
          conv_d = 1'b1;
          st_d   = StOutRd;
        end else begin
          cur_d = ~cur_q;
          if (it_q == guard) begin
            conv_d = 1'b0;
            st_d   = StOutRd;
          end else st_d = StPass;
        end
      end
      // readout, one node at a time, each held until the output takes it
      StOutRd: begin
        rk_ra = {obank_q, idx_q};
        st_d  = StOut;
      end
      StOut: begin
        rk_ra       = {obank_q, idx_q};
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (last_node) begin
            clear_o = 1'b1;
            st_d    = StIdle;
          end else begin
            idx_d = idx_q + 1'b1;
            st_d  = StOutRd;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      idx_q   <= '0;
      e_q     <= '0;
      n_q     <= NodeCntW'(MaxNodes);
      cur_q   <= 1'b0;
      obank_q <= 1'b0;
      it_q    <= '0;
      moved_q <= 1'b0;
      conv_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      idx_q   <= idx_d;
      e_q     <= e_d;
      n_q     <= n_d;
      cur_q   <= cur_d;
      obank_q <= obank_d;
      it_q    <= it_d;
      moved_q <= moved_d;
      conv_q  <= conv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsum_q   <= dsum_d;
    tel_q    <= tel_d;
    init_q   <= init_d;
    base_q   <= base_d;
    scaled_q <= scaled_d;
    rank_q   <= rank_d;
    deg_q    <= deg_d;
    prod_q   <= prod_d;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (rk_we) rank_mem[rk_wa] <= rk_wd;
    rk_a_q <= rank_mem[rk_ra];
    rk_b_q <= rank_mem[rk_rb];
    if (sh_we) share_mem[sh_wa] <= sh_wd;
    sh_q <= share_mem[sh_ra];
    if (dg_we) deg_mem[dg_wa] <= dg_wd;
    dg_q <= deg_mem[dg_ra];
  end

  assign e_addr_o = e_q;
  assign busy_o   = (st_q != StIdle);

  assign res_o.node_index      = idx_q;
  assign res_o.rank_value      = rk_a_q[RankW-1:0];
  assign res_o.iterations_done = it_q;
  assign res_o.converged       = conv_q;
  assign res_o.last_result     = last_node;

endmodule

/* rtl/core/prpi_checker.sv */
// ----------------------------------------------------------------------------
// prpi_checker
// Port-level checks of the PageRank core, bound to the top level.
// ----------------------------------------------------------------------------
module prpi_checker import prpi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [1:0]       req_type_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [RankW-1:0] rank_value_o,
  input logic [ItW-1:0]   iterations_done_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rank_value_o))
    else $error("stalled result changed");

  // a run request closes the input side
  a_run_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == ReqAddRun || req_type_i == ReqRun)
    |=> in_stall_o)
    else $error("input open after run request");

  // ranks never exceed one
  a_rank_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rank_value_o <= RankOne)
    else $error("rank above one");

  // every run does at least one pass
  a_iter_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iterations_done_o != '0)
    else $error("result with zero passes");

endmodule

bind pagerank_power_iteration_core prpi_checker u_prpi_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .req_type_i        (req_type_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .rank_value_o      (rank_value_o),
  .iterations_done_o (iterations_done_o)
);

/* dv/pagerank_power_iteration_core_tb.sv */
// ----------------------------------------------------------------------------
// pagerank_power_iteration_core_tb
// Self-checking bench for the PageRank core. Requests stream in through the
// valid/stall channel. A bit-exact rank predictor computes each run's
// per-node results. A monitor compares every result against the oldest
// queued prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module pagerank_power_iteration_core_tb;
  import prpi_pkg::*;

  localparam logic [1:0] ReqIgnored = 2'd3;
  localparam int         CycleLimit = 4_000_000;

  typedef struct packed {
    logic [NodeW-1:0] node_index;
    logic [RankW-1:0] rank_value;
    logic [ItW-1:0]   iterations_done;
    logic             converged;
    logic             edges_dropped;
    logic             last_result;
  } rank_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [ThrW-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          req_type_i = ReqAdd;
  logic [NodeW-1:0]    src_node_i = '0;
  logic [NodeW-1:0]    dst_node_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [NodeW-1:0]    node_index_o;
  logic [RankW-1:0]    rank_value_o;
  logic [ItW-1:0]      iterations_done_o;
  logic                converged_o;
  logic                edges_dropped_o;
  logic                last_result_o;

  pagerank_power_iteration_core uut (.*);

  always #2 clk_i = ~clk_i;

  // predictor copy of the graph and the registers
  logic [NodeW-1:0]    src_store[MaxEdges];
  logic [NodeW-1:0]    dst_store[MaxEdges];
  int unsigned         stored_edges;
  bit                  dropped_seen;
  logic [NodeCntW-1:0] nodes_reg;
  logic [DampW-1:0]    damping_reg;
  logic [ThrW-1:0]     threshold_reg;
  logic [ItW-1:0]      guard_reg;

  rank_result_t expected_ranks[$];
  int  fail_count;
  int  results_seen;
  int  runs_started;
  int  requests_sent;
  bit  quiet;
  int  unsigned cycle_count = 0;

  // run the power iteration on the stored graph and queue one result per node
  function automatic void predict_ranks();
    int unsigned       n, guard, iters, deg[MaxNodes];
    longint unsigned   one, a, thr, tele, dsum, base, diff;
    longint unsigned   cur[MaxNodes], nxt[MaxNodes], share[MaxNodes];
    bit                conv, moved;
    rank_result_t      r;
    n = nodes_reg;
    if (n < 1) n = 1;
    if (n > MaxNodes) n = MaxNodes;
    guard = (guard_reg == 0) ? 1 : guard_reg;
    one = 64'd1 << 31;
    a = damping_reg;
    thr = threshold_reg;
    for (int i = 0; i < MaxNodes; i++) deg[i] = 0;
    for (int e = 0; e < stored_edges; e++)
      if (src_store[e] < n && dst_store[e] < n) deg[src_store[e]]++;
    tele = ((64'd65536 - a) << 31) / (longint'(n) << 16);
    for (int i = 0; i < n; i++) cur[i] = one / n;
    iters = 0;
    conv = 0;
    while (!conv && iters < guard) begin
      iters++;
      dsum = 0;
      moved = 0;
      for (int i = 0; i < n; i++) begin
        if (deg[i] == 0) begin
          dsum += cur[i];
          share[i] = 0;
        end else begin
          share[i] = ((a * cur[i]) >> 16) / deg[i];
        end
      end
      base = tele + ((a * dsum) >> 16) / n;
      for (int i = 0; i < n; i++) nxt[i] = base;
      for (int e = 0; e < stored_edges; e++)
        if (src_store[e] < n && dst_store[e] < n)
          nxt[dst_store[e]] += share[src_store[e]];
      for (int i = 0; i < n; i++) begin
        if (nxt[i] > one) nxt[i] = one;
        diff = (nxt[i] > cur[i]) ? nxt[i] - cur[i] : cur[i] - nxt[i];
        if (diff > thr) moved = 1;
      end
      if (moved) for (int i = 0; i < n; i++) cur[i] = nxt[i];
      else conv = 1;
    end
    for (int i = 0; i < n; i++) begin
      r.node_index      = i[NodeW-1:0];
      r.rank_value      = nxt[i][31:0];
      r.iterations_done = iters[ItW-1:0];
      r.converged       = conv;
      r.edges_dropped   = dropped_seen;
      r.last_result     = (i == n - 1);
      expected_ranks    = {expected_ranks, r};
    end
    stored_edges = 0;
    dropped_seen = 0;
    runs_started++;
  endfunction

  function automatic void store_edge(logic [NodeW-1:0] s, logic [NodeW-1:0] d);
    if (stored_edges >= MaxEdges) begin
      dropped_seen = 1;
    end else begin
      src_store[stored_edges] = s;
      dst_store[stored_edges] = d;
      stored_edges++;
    end
  endfunction

  // cycle guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // random stall on the result side
  always @(negedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 13);
  end

  // result monitor
  always @(posedge clk_i) begin
    rank_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_ranks.size() == 0) begin
        $error("unexpected result for node %0d", node_index_o);
        fail_count++;
      end else begin
        e = expected_ranks.pop_front();
        if (node_index_o !== e.node_index) begin
          $error("node_index exp %0d got %0d", e.node_index, node_index_o);
          fail_count++;
        end
        if (rank_value_o !== e.rank_value) begin
          $error("rank_value exp %h got %h", e.rank_value, rank_value_o);
          fail_count++;
        end
        if (iterations_done_o !== e.iterations_done) begin
          $error("iterations_done exp %0d got %0d", e.iterations_done,
                 iterations_done_o);
          fail_count++;
        end
        if (converged_o !== e.converged) begin
          $error("converged exp %0b got %0b", e.converged, converged_o);
          fail_count++;
        end
        if (edges_dropped_o !== e.edges_dropped) begin
          $error("edges_dropped exp %0b got %0b", e.edges_dropped, edges_dropped_o);
          fail_count++;
        end
        if (last_result_o !== e.last_result) begin
          $error("last_result exp %0b got %0b", e.last_result, last_result_o);
          fail_count++;
        end
      end
    end
  end

  // one request, with optional idle gaps before it
  task automatic send_request(logic [1:0] kind, logic [NodeW-1:0] s,
                              logic [NodeW-1:0] d);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = kind;
    src_node_i = s;
    dst_node_i = d;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
    if (kind == ReqAdd || kind == ReqAddRun) store_edge(s, d);
    if (kind == ReqAddRun || kind == ReqRun) predict_ranks();
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [ThrW-1:0] value);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgNodeCount: nodes_reg = value[NodeCntW-1:0];
      CfgDamping:   damping_reg = value[DampW-1:0];
      CfgThreshold: threshold_reg = value;
      CfgMaxIter:   guard_reg = value[ItW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int n, int damp, logic [31:0] thr, int guard);
    write_register(CfgNodeCount, n);
    write_register(CfgDamping, damp);
    write_register(CfgThreshold, thr);
    write_register(CfgMaxIter, guard);
  endtask

  // reset values: small ring plus a dangling tail, runs to convergence
  task automatic test_default_config();
    send_request(ReqAdd, 0, 1);
    send_request(ReqAdd, 1, 2);
    send_request(ReqAdd, 2, 0);
    send_request(ReqAddRun, 63, 62);
  endtask

  // register extremes and special request forms
  task automatic test_extremes();
    set_config(0, 0, 0, 0);
    send_request(ReqAdd, 0, 0);
    send_request(ReqRun, 0, 0);
    set_config(127, 65535, 32'hFFFF_FFFF, 65535);
    send_request(ReqAdd, 63, 0);
    send_request(ReqAdd, 0, 63);
    send_request(ReqAddRun, 5, 5);
    set_config(64, 65535, 0, 6);
    send_request(ReqAdd, 1, 2);
    send_request(ReqAdd, 1, 2);
    send_request(ReqAddRun, 2, 1);
    set_config(3, 65535, 32'h8000_0000, 1);
    send_request(ReqRun, 0, 0);
  endtask

  // ignored request type and edges past the node count
  task automatic test_ignored_and_outside();
    set_config(4, 55706, 2, 40);
    send_request(ReqIgnored, 6'h3F, 6'h3F);
    send_request(ReqAdd, 0, 1);
    send_request(ReqAdd, 1, 9);
    send_request(ReqAdd, 9, 2);
    send_request(ReqIgnored, 1, 0);
    send_request(ReqAdd, 3, 0);
    send_request(ReqRun, 0, 0);
  endtask

  // fill the edge store past its capacity, then run
  task automatic test_store_overflow();
    set_config(2, 40000, 1000, 1);
    quiet = 1;
    for (int i = 0; i < MaxEdges + 2; i++)
      send_request(ReqAdd, NodeW'($urandom_range(0, 63)),
                   NodeW'($urandom_range(0, 63)));
    send_request(ReqAddRun, 0, 1);
    quiet = 0;
    // the store was cleared by the run, so no drop should show now
    send_request(ReqAddRun, 1, 0);
  endtask

  // hold the sender until all pending ranks have come back
  task automatic test_drain_pause();
    send_request(ReqAdd, 0, 1);
    send_request(ReqAddRun, 1, 0);
    wait_drain();
    send_request(ReqRun, 0, 0);
  endtask

  // random graphs under changing settings
  task automatic test_random_graphs(int budget);
    int sent, n, edges, pick, top;
    logic [31:0] thr;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? 64 : (pick == 1) ? $urandom_range(65, 127) :
          (pick == 2) ? 0 : $urandom_range(1, 10);
      pick = $urandom_range(0, 3);
      thr = (pick == 0) ? 0 : (pick == 1) ? $urandom : $urandom_range(1, 5000);
      set_config(n, $urandom_range(0, 65535), thr, $urandom_range(1, 12));
      top = (n > 0 && n < 64) ? n - 1 : 63;
      for (int r = 0; r < 4 && sent < budget; r++) begin
        edges = $urandom_range(0, 12);
        for (int e = 0; e < edges; e++) begin
          if ($urandom_range(0, 19) == 0)
            send_request(ReqIgnored, NodeW'($urandom), NodeW'($urandom));
          else if ($urandom_range(0, 9) == 0)
            send_request(ReqAdd, NodeW'($urandom), NodeW'($urandom));
          else
            send_request(ReqAdd, NodeW'($urandom_range(0, top)),
                         NodeW'($urandom_range(0, top)));
          sent++;
        end
        send_request($urandom_range(0, 1) ? ReqAddRun : ReqRun,
                     NodeW'($urandom_range(0, 63)), NodeW'($urandom_range(0, 63)));
        sent++;
      end
    end
  endtask

  initial begin
    stored_edges = 0;
    dropped_seen = 0;
    nodes_reg = 64;
    damping_reg = 55706;
    threshold_reg = 2;
    guard_reg = 1000;
    fail_count = 0;
    results_seen = 0;
    runs_started = 0;
    requests_sent = 0;
    quiet = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_config();
    quiet = 0;
    test_extremes();
    test_ignored_and_outside();
    test_drain_pause();
    test_store_overflow();
    quiet = 1;
    test_random_graphs(60);
    quiet = 0;
    test_random_graphs(290);
    wait_drain();
    repeat (200) @(posedge clk_i);
    $display("run covered %0d requests, %0d rank runs, %0d results checked",
             requests_sent, runs_started, results_seen);
    $display("incl. register extremes, ignored requests, outside edges, store overflow");
    if (fail_count == 0 && expected_ranks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/prpi_pkg.sv
rtl/core/prpi_div.sv
rtl/core/prpi_edge_store.sv
rtl/core/prpi_engine.sv
rtl/core/pagerank_power_iteration_core.sv
rtl/core/prpi_checker.sv
dv/pagerank_power_iteration_core_tb.sv
